/* rtl/core/pqe_pkg.sv */
package pqe_pkg;

    // One particle record, as it arrives on the input channel.
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] life_left;
        logic        [30:0] life_total;
        logic        [15:0] angle_in;
        logic        [30:0] start_size;
        logic        [19:0] time_step;
    } pqe_in_t;

    // One quad corner, or the single beat of a removed particle.
    typedef struct packed {
        logic signed [31:0] corner_x;
        logic signed [31:0] corner_y;
        logic signed [31:0] corner_z;
        logic        [31:0] corner_colour;
        logic        [1:0]  corner_index;
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_life;
        logic        [15:0] new_angle;
        logic               alive;
        logic               last;
    } pqe_out_t;

    typedef enum logic [1:0] {
        CFG_START_COLOUR = 2'd0,
        CFG_FINAL_COLOUR = 2'd1,
        CFG_FINAL_SIZE   = 2'd2
    } pqe_cfg_idx_t;

    localparam logic [31:0] START_COLOUR_RST = 32'hFFFF_FFFF;
    localparam logic [31:0] FINAL_COLOUR_RST = 32'h0000_0000;
    localparam logic [30:0] FINAL_SIZE_RST   = 31'd0;

    // 0.1 rad per time unit, expressed in 1/65536 turn with 16 fraction bits.
    localparam logic [26:0] ROT_RATE_Q16 = 27'd68356528;
    localparam logic [16:0] ONE_Q16      = 17'd65536;
    localparam logic [14:0] QUARTER_TURN = 15'd16384;

    // Odd polynomial for the quarter-wave sine, Q16.
    localparam logic [16:0] SIN_C1 = 17'd102944;
    localparam logic [16:0] SIN_C3 = 17'd42334;
    localparam logic [16:0] SIN_C5 = 17'd5223;
    localparam logic [8:0]  SIN_C7 = 9'd297;

    // Ratio divider: 16 quotient bits, two per pipeline stage.
    localparam int DIV_STAGES = 8;
    localparam int DIV_BITS   = 2;

endpackage

/* rtl/core/particle_quad_expander_core.sv */
// Billboard quad expander for 2D particles. Each input beat is one particle
// record; a live particle gives four result beats (corners 0 to 3, last set on
// corner 3), a particle whose life is already at or below zero gives one beat
// with alive clear and last set. The datapath holds fourteen register stages:
// the input register, the velocity and angle products, eight divider stages
// that each retire two bits of the life ratio while the sine and cosine
// polynomials run alongside (the first of them also takes the integrated
// position, the advanced angle and the divider and sine setup), the colour and
// size blend, the pivot, the rotation products and the corner holding register.
// The first beat of a particle is presented once its record has passed every
// stage above in order. While the result channel is ready, the corner holding
// register sends one beat per cycle, so a live particle takes four beats of
// the result channel and a removed one takes one; that register bounds the
// sustained particle rate of the block. Every stage
// has its own valid bit, so empty stages fill while the result channel stalls.
// Configuration writes are taken in every cycle and are meant to happen while
// the block is idle.
module particle_quad_expander_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pqe_pkg::pqe_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pqe_pkg::pqe_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    // Stage records. Every stage carries the write-back fields so that a
    // removed particle simply rides the pipeline with its echoed values.
    typedef struct packed {
        logic               dead;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] nlife;
        logic        [15:0] ang;
        logic        [30:0] total;
        logic        [30:0] ssize;
        logic signed [52:0] mx;
        logic signed [52:0] my;
        logic        [46:0] angd;
    } s1_t;

    typedef struct packed {
        logic               dead;
        logic signed [31:0] pz;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nlife;
        logic        [15:0] nang;
        logic        [30:0] total;
        logic        [30:0] ssize;
        logic               rzero;
        logic               rone;
        logic        [31:0] rem;
        logic        [15:0] quo;
        logic        [16:0] zs;
        logic        [16:0] zc;
        logic        [16:0] z2s;
        logic        [16:0] z2c;
        logic        [16:0] ps;
        logic        [16:0] pc;
        logic               ns;
        logic               nc;
    } dv_t;

    typedef struct packed {
        logic               dead;
        logic signed [31:0] pz;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nlife;
        logic        [15:0] nang;
        logic        [47:0] hf;
        logic        [47:0] hs;
        logic        [31:0] colour;
        logic signed [17:0] sn;
        logic signed [17:0] cs;
    } s3_t;

    typedef struct packed {
        logic               dead;
        logic signed [31:0] pz;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nlife;
        logic        [15:0] nang;
        logic        [31:0] colour;
        logic        [30:0] h;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [17:0] sn;
        logic signed [17:0] cs;
    } s4_t;

    typedef struct packed {
        logic               dead;
        logic signed [31:0] pz;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nlife;
        logic        [15:0] nang;
        logic        [31:0] colour;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [49:0] a;
        logic signed [49:0] b;
    } s5_t;

    typedef struct packed {
        logic               dead;
        logic signed [31:0] pz;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nlife;
        logic        [15:0] nang;
        logic        [31:0] colour;
        logic signed [31:0] x0;
        logic signed [31:0] y0;
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [31:0] x2;
        logic signed [31:0] y2;
        logic signed [31:0] x3;
        logic signed [31:0] y3;
    } s6_t;

    localparam int NDIV = pqe_pkg::DIV_STAGES;

    // Round a Q16 fraction away, halves toward plus infinity.
    function automatic logic [31:0] rnd16(input logic signed [50:0] v);
        logic signed [50:0] t;
        t = v + 51'sd32768;
        return t[47:16];
    endfunction

    // Configuration registers.
    logic [31:0] start_colour_reg;
    logic [31:0] final_colour_reg;
    logic [30:0] final_size_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_colour_reg <= pqe_pkg::START_COLOUR_RST;
            final_colour_reg <= pqe_pkg::FINAL_COLOUR_RST;
            final_size_reg   <= pqe_pkg::FINAL_SIZE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                pqe_pkg::CFG_START_COLOUR: start_colour_reg <= cfg_data;
                pqe_pkg::CFG_FINAL_COLOUR: final_colour_reg <= cfg_data;
                pqe_pkg::CFG_FINAL_SIZE:   final_size_reg   <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Pipeline registers, valid bits and per-stage enables. A stage loads
    // when it is empty or when the stage after it loads in the same cycle.
    pqe_pkg::pqe_in_t s0_reg;
    s1_t              s1_reg, s1_next;
    dv_t              s2_next;
    dv_t              dv_reg  [NDIV];
    dv_t              dv_in   [NDIV];
    dv_t              dv_next [NDIV];
    logic             dv_v_reg [NDIV];
    logic             dv_v_in  [NDIV];
    logic             en_d     [NDIV];
    s3_t              s3_reg, s3_next;
    s4_t              s4_reg, s4_next;
    s5_t              s5_reg, s5_next;
    s6_t              s6_reg, s6_next;
    logic             s0_v_reg, s1_v_reg, s3_v_reg, s4_v_reg, s5_v_reg, s6_v_reg;
    logic             en0, en1, en3, en4, en5, en6;
    logic [1:0]       cnt_reg;
    logic             beat_last;

    assign beat_last = s6_reg.dead || (cnt_reg == 2'd3);
    assign en6 = !s6_v_reg || (m_ready && beat_last);
    assign en5 = !s5_v_reg || en6;
    assign en4 = !s4_v_reg || en5;
    assign en3 = !s3_v_reg || en4;
    assign en1 = !s1_v_reg || en_d[0];
    assign en0 = !s0_v_reg || en1;
    assign s_ready = en0;

    // Stage 1: life decrement, velocity and angle-rate products.
    always_comb begin
        s1_next.dead  = s0_reg.life_left[31] || (s0_reg.life_left == 32'sd0);
        s1_next.px    = s0_reg.pos_x;
        s1_next.py    = s0_reg.pos_y;
        s1_next.pz    = s0_reg.pos_z;
        s1_next.nlife = s1_next.dead ? s0_reg.life_left
                      : s0_reg.life_left - $signed({12'd0, s0_reg.time_step});
        s1_next.ang   = s0_reg.angle_in;
        s1_next.total = s0_reg.life_total;
        s1_next.ssize = s0_reg.start_size;
        s1_next.mx    = s0_reg.vel_x * $signed({1'b0, s0_reg.time_step});
        s1_next.my    = s0_reg.vel_y * $signed({1'b0, s0_reg.time_step});
        s1_next.angd  = s0_reg.time_step * pqe_pkg::ROT_RATE_Q16;
    end

    // Stage 2: integrate, advance the angle, set up divider and sine inputs.
    always_comb begin
        logic signed [52:0] rx;
        logic signed [52:0] ry;
        logic        [47:0] ra;
        logic        [15:0] nang;
        logic        [1:0]  qs;
        logic        [1:0]  qc;
        logic        [14:0] ts;
        logic        [14:0] tc;
        rx   = (s1_reg.mx + 53'sd32768) >>> 16;
        ry   = (s1_reg.my + 53'sd32768) >>> 16;
        ra   = {1'b0, s1_reg.angd} + 48'h0000_8000_0000;
        nang = s1_reg.ang + ra[47:32];

        s2_next.dead  = s1_reg.dead;
        s2_next.pz    = s1_reg.pz;
        s2_next.nx    = s1_reg.dead ? s1_reg.px : s1_reg.px + $signed(rx[31:0]);
        s2_next.ny    = s1_reg.dead ? s1_reg.py : s1_reg.py + $signed(ry[31:0]);
        s2_next.nlife = s1_reg.nlife;
        s2_next.nang  = s1_reg.dead ? s1_reg.ang : nang;
        s2_next.total = s1_reg.total;
        s2_next.ssize = s1_reg.ssize;
        s2_next.rzero = s1_reg.nlife[31] || (s1_reg.nlife == 32'sd0);
        s2_next.rone  = !s2_next.rzero && (s1_reg.nlife[30:0] >= s1_reg.total);
        s2_next.rem   = {1'b0, s1_reg.nlife[30:0]};
        s2_next.quo   = 16'd0;

        // Cosine is the sine a quarter turn later: same offset, next quadrant.
        qs = s2_next.nang[15:14];
        qc = qs + 2'd1;
        ts = qs[0] ? pqe_pkg::QUARTER_TURN - {1'b0, s2_next.nang[13:0]}
                   : {1'b0, s2_next.nang[13:0]};
        tc = qc[0] ? pqe_pkg::QUARTER_TURN - {1'b0, s2_next.nang[13:0]}
                   : {1'b0, s2_next.nang[13:0]};
        s2_next.zs  = {ts, 2'b00};
        s2_next.zc  = {tc, 2'b00};
        s2_next.z2s = 17'd0;
        s2_next.z2c = 17'd0;
        s2_next.ps  = 17'd0;
        s2_next.pc  = 17'd0;
        s2_next.ns  = qs[1];
        s2_next.nc  = qc[1];
    end

    // Divider stages. Each retires two quotient bits by restoring division;
    // the remainder stays below the divisor, so doubling it fits 32 bits.
    // The first five stages also step the sine and cosine polynomials.
    genvar k;
    for (k = 0; k < NDIV; k++) begin : g_div
        if (k == 0) begin : g_first
            assign dv_in[k]   = s2_next;
            assign dv_v_in[k] = s1_v_reg;
        end else begin : g_rest
            assign dv_in[k]   = dv_reg[k-1];
            assign dv_v_in[k] = dv_v_reg[k-1];
        end

        if (k == NDIV - 1) begin : g_en_last
            assign en_d[k] = !dv_v_reg[k] || en3;
        end else begin : g_en_mid
            assign en_d[k] = !dv_v_reg[k] || en_d[k+1];
        end

        always_comb begin
            logic [31:0] rem;
            logic [31:0] dvs;
            logic [15:0] quo;
            logic [33:0] prs;
            logic [33:0] prc;
            logic [17:0] ss;
            logic [17:0] sc;
            dv_next[k] = dv_in[k];
            rem = dv_in[k].rem;
            quo = dv_in[k].quo;
            dvs = {1'b0, dv_in[k].total};
            for (int i = 0; i < pqe_pkg::DIV_BITS; i++) begin
                rem = {rem[30:0], 1'b0};
                if (rem >= dvs) begin
                    rem = rem - dvs;
                    quo = {quo[14:0], 1'b1};
                end else begin
                    quo = {quo[14:0], 1'b0};
                end
            end
            dv_next[k].rem = rem;
            dv_next[k].quo = quo;

            prs = 34'd0;
            prc = 34'd0;
            ss  = 18'd0;
            sc  = 18'd0;
            if (k == 0) begin
                prs = dv_in[k].zs * dv_in[k].zs;
                prc = dv_in[k].zc * dv_in[k].zc;
                dv_next[k].z2s = prs[32:16];
                dv_next[k].z2c = prc[32:16];
            end else if (k == 1) begin
                prs = dv_in[k].z2s * pqe_pkg::SIN_C7;
                prc = dv_in[k].z2c * pqe_pkg::SIN_C7;
                dv_next[k].ps = pqe_pkg::SIN_C5 - prs[32:16];
                dv_next[k].pc = pqe_pkg::SIN_C5 - prc[32:16];
            end else if (k == 2) begin
                prs = dv_in[k].z2s * dv_in[k].ps;
                prc = dv_in[k].z2c * dv_in[k].pc;
                dv_next[k].ps = pqe_pkg::SIN_C3 - prs[32:16];
                dv_next[k].pc = pqe_pkg::SIN_C3 - prc[32:16];
            end else if (k == 3) begin
                prs = dv_in[k].z2s * dv_in[k].ps;
                prc = dv_in[k].z2c * dv_in[k].pc;
                dv_next[k].ps = pqe_pkg::SIN_C1 - prs[32:16];
                dv_next[k].pc = pqe_pkg::SIN_C1 - prc[32:16];
            end else if (k == 4) begin
                prs = dv_in[k].zs * dv_in[k].ps;
                prc = dv_in[k].zc * dv_in[k].pc;
                ss  = prs[33:16];
                sc  = prc[33:16];
                dv_next[k].ps = (ss > {1'b0, pqe_pkg::ONE_Q16}) ? pqe_pkg::ONE_Q16 : ss[16:0];
                dv_next[k].pc = (sc > {1'b0, pqe_pkg::ONE_Q16}) ? pqe_pkg::ONE_Q16 : sc[16:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[k] <= 1'b0;
            end else if (en_d[k]) begin
                dv_v_reg[k] <= dv_v_in[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en_d[k]) begin
                dv_reg[k] <= dv_next[k];
            end
        end
    end

    // Stage 3: pick the ratio, form the blend products and the colour.
    always_comb begin
        logic [16:0] r;
        logic [16:0] om;
        logic [25:0] csum;
        dv_t         d;
        d  = dv_reg[NDIV-1];
        r  = d.rone ? pqe_pkg::ONE_Q16 : (d.rzero ? 17'd0 : {1'b0, d.quo});
        om = pqe_pkg::ONE_Q16 - r;
        s3_next.dead  = d.dead;
        s3_next.pz    = d.pz;
        s3_next.nx    = d.nx;
        s3_next.ny    = d.ny;
        s3_next.nlife = d.nlife;
        s3_next.nang  = d.nang;
        s3_next.hf    = final_size_reg * om;
        s3_next.hs    = d.ssize * r;
        for (int b = 0; b < 4; b++) begin
            csum = final_colour_reg[8*b +: 8] * om + start_colour_reg[8*b +: 8] * r
                 + 26'd32768;
            s3_next.colour[8*b +: 8] = csum[23:16];
        end
        s3_next.sn = d.ns ? -$signed({1'b0, d.ps}) : $signed({1'b0, d.ps});
        s3_next.cs = d.nc ? -$signed({1'b0, d.pc}) : $signed({1'b0, d.pc});
    end

    // Stage 4: half size and the rotation pivot.
    always_comb begin
        logic [48:0] hsum;
        hsum = {1'b0, s3_reg.hf} + {1'b0, s3_reg.hs} + 49'd65536;
        s4_next.dead   = s3_reg.dead;
        s4_next.pz     = s3_reg.pz;
        s4_next.nx     = s3_reg.nx;
        s4_next.ny     = s3_reg.ny;
        s4_next.nlife  = s3_reg.nlife;
        s4_next.nang   = s3_reg.nang;
        s4_next.colour = s3_reg.colour;
        s4_next.h      = hsum[47:17];
        s4_next.cx     = s3_reg.nx + $signed({1'b0, hsum[47:17]});
        s4_next.cy     = s3_reg.ny - $signed({1'b0, hsum[47:17]});
        s4_next.sn     = s3_reg.sn;
        s4_next.cs     = s3_reg.cs;
    end

    // Stage 5: rotation products h*sin and h*cos.
    always_comb begin
        s5_next.dead   = s4_reg.dead;
        s5_next.pz     = s4_reg.pz;
        s5_next.nx     = s4_reg.nx;
        s5_next.ny     = s4_reg.ny;
        s5_next.nlife  = s4_reg.nlife;
        s5_next.nang   = s4_reg.nang;
        s5_next.colour = s4_reg.colour;
        s5_next.cx     = s4_reg.cx;
        s5_next.cy     = s4_reg.cy;
        s5_next.a      = $signed({1'b0, s4_reg.h}) * s4_reg.sn;
        s5_next.b      = $signed({1'b0, s4_reg.h}) * s4_reg.cs;
    end

    // Stage 6: all four corners. With offsets of -h, 0 or +h the rotated
    // terms reduce to sums of a = h*sin and b = h*cos.
    always_comb begin
        logic signed [50:0] a;
        logic signed [50:0] b;
        a = s5_reg.a;
        b = s5_reg.b;
        s6_next.dead   = s5_reg.dead;
        s6_next.pz     = s5_reg.pz;
        s6_next.nx     = s5_reg.nx;
        s6_next.ny     = s5_reg.ny;
        s6_next.nlife  = s5_reg.nlife;
        s6_next.nang   = s5_reg.nang;
        s6_next.colour = s5_reg.colour;
        s6_next.x0     = s5_reg.cx + $signed(rnd16(a - b));
        s6_next.y0     = s5_reg.cy + $signed(rnd16(a + b));
        s6_next.x1     = s5_reg.cx + $signed(rnd16(-b));
        s6_next.y1     = s5_reg.cy + $signed(rnd16(a));
        s6_next.x2     = s5_reg.cx;
        s6_next.y2     = s5_reg.cy;
        s6_next.x3     = s5_reg.cx + $signed(rnd16(a));
        s6_next.y3     = s5_reg.cy + $signed(rnd16(b));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_v_reg <= 1'b0;
            s1_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (en0) s0_v_reg <= s_valid;
            if (en1) s1_v_reg <= s0_v_reg;
            if (en3) s3_v_reg <= dv_v_reg[NDIV-1];
            if (en4) s4_v_reg <= s3_v_reg;
            if (en5) s5_v_reg <= s4_v_reg;
            if (en6) begin
                s6_v_reg <= s5_v_reg;
                cnt_reg  <= 2'd0;
            end else if (m_ready) begin
                cnt_reg <= cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en0) s0_reg <= s_data;
        if (en1) s1_reg <= s1_next;
        if (en3) s3_reg <= s3_next;
        if (en4) s4_reg <= s4_next;
        if (en5) s5_reg <= s5_next;
        if (en6) s6_reg <= s6_next;
    end

    // Result beat: a removed particle shows zeros in the corner fields.
    always_comb begin
        m_data.new_pos_x = s6_reg.nx;
        m_data.new_pos_y = s6_reg.ny;
        m_data.new_life  = s6_reg.nlife;
        m_data.new_angle = s6_reg.nang;
        m_data.alive     = !s6_reg.dead;
        m_data.last      = beat_last;
        if (s6_reg.dead) begin
            m_data.corner_x      = 32'sd0;
            m_data.corner_y      = 32'sd0;
            m_data.corner_z      = 32'sd0;
            m_data.corner_colour = 32'd0;
            m_data.corner_index  = 2'd0;
        end else begin
            m_data.corner_z      = s6_reg.pz;
            m_data.corner_colour = s6_reg.colour;
            m_data.corner_index  = cnt_reg;
            case (cnt_reg)
                2'd0: begin
                    m_data.corner_x = s6_reg.x0;
                    m_data.corner_y = s6_reg.y0;
                end
                2'd1: begin
                    m_data.corner_x = s6_reg.x1;
                    m_data.corner_y = s6_reg.y1;
                end
                2'd2: begin
                    m_data.corner_x = s6_reg.x2;
                    m_data.corner_y = s6_reg.y2;
                end
                default: begin
                    m_data.corner_x = s6_reg.x3;
                    m_data.corner_y = s6_reg.y3;
                end
            endcase
        end
    end

    assign m_valid = s6_v_reg;

    // A removed particle always ends on its only beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.alive |-> m_data.last)
        else $error("removed particle beat without last");

    // Corners of a live particle follow in order without a gap in numbering.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last |=>
            m_valid && m_data.alive &&
            (m_data.corner_index == $past(m_data.corner_index) + 2'd1))
        else $error("corner sequence broken");

    // The write-back x position, life and angle stay fixed across the beats of one particle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last |=>
            $stable(m_data.new_pos_x) && $stable(m_data.new_life) &&
            $stable(m_data.new_angle))
        else $error("write-back fields changed within a particle");

endmodule
